// File: rtl/core/mfs_pkg.sv
// shared types, constants and helpers of the multilevel feedback scheduler
package mfs_pkg;

  localparam int unsigned LAST_LEVEL  = 3;
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned NUM_LEVELS  = LAST_LEVEL + 1;

  localparam int unsigned LVL_IDX_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int unsigned PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ADDR_W    = $clog2(NUM_LEVELS * QUEUE_DEPTH);

  localparam int unsigned ID_W    = 8;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned SUM_W   = TIME_W + 1;
  localparam int unsigned LEVEL_W = 3;

  localparam logic [LVL_IDX_W-1:0] LAST_IDX  = LVL_IDX_W'(LAST_LEVEL);
  localparam logic [PTR_W-1:0]     PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]     CNT_FULL  = CNT_W'(QUEUE_DEPTH);
  localparam logic [ADDR_W-1:0]    ROW_SPAN  = ADDR_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_REQUEUE = 2'd1,
    OP_SELECT  = 2'd2,
    OP_CHECK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_CLAMP = 2'd2
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   proc_id;
    logic [TIME_W-1:0] done_time;
    logic [TIME_W-1:0] elapsed_time;
    logic [TIME_W-1:0] service_time;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [LEVEL_W-1:0] sel_level;
    logic               keep_running;
    logic               none_waiting;
    status_e            status;
  } res_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ID_W-1:0]   wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [LVL_IDX_W-1:0] lvl,
                                                   input logic [PTR_W-1:0] ptr);
    return ADDR_W'(lvl) * ROW_SPAN + ADDR_W'(ptr);
  endfunction

endpackage

// File: rtl/core/mfs_if.sv
// request and response channel interfaces of the scheduler
interface mfs_req_if;
  logic                          valid;
  logic                          ready;
  mfs_pkg::op_e                  op;
  logic [mfs_pkg::ID_W-1:0]      proc_id;
  logic [mfs_pkg::TIME_W-1:0]    done_time;
  logic [mfs_pkg::TIME_W-1:0]    elapsed_time;
  logic [mfs_pkg::TIME_W-1:0]    service_time;

  modport source (output valid, op, proc_id, done_time, elapsed_time, service_time,
                  input ready);
  modport sink   (input valid, op, proc_id, done_time, elapsed_time, service_time,
                  output ready);
endinterface

interface mfs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [mfs_pkg::ID_W-1:0]      sel_id;
  logic [mfs_pkg::LEVEL_W-1:0]   sel_level;
  logic                          keep_running;
  logic                          none_waiting;
  mfs_pkg::status_e              status;

  modport source (output valid, found, sel_id, sel_level, keep_running, none_waiting,
                  status, input ready);
  modport sink   (input valid, found, sel_id, sel_level, keep_running, none_waiting,
                  status, output ready);
endinterface

// File: rtl/core/multilevel_feedback_scheduler.sv
// multilevel feedback queue scheduler top level
//
//   channel  dir  handshake     carries
//   req_i    in   valid/ready   op, proc_id, done_time, elapsed_time, service_time
//   rsp_o    out  valid/ready   found, sel_id, sel_level, keep_running, none_waiting, status
//
// one request per cycle unless rsp_o stalls; a request passes the input register
// and then the result register before its response is valid, and the store read register
// sits beside the result register so selected ids are registered together with the result
// reset clears pointers, level counts and the running level; the id store is not cleared
// a stalled response holds res_q and a full s1_q; req_i.ready drops only when both are full
module multilevel_feedback_scheduler (
  input  logic  clk_i,
  input  logic  rst_ni,
  mfs_req_if.sink   req_i,
  mfs_rsp_if.source rsp_o
);
  import mfs_pkg::*;

  logic            s1_valid_q;
  req_t            s1_q;
  logic            out_valid_q;
  res_t            res_d, res_q;
  logic            adv;
  mem_req_t        mem_req;
  logic [ID_W-1:0] rd_data;

  assign adv         = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      s1_q <= '{op: req_i.op, proc_id: req_i.proc_id, done_time: req_i.done_time,
                elapsed_time: req_i.elapsed_time, service_time: req_i.service_time};
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  mfs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .req_i     (s1_q),
    .res_o     (res_d),
    .mem_req_o (mem_req)
  );

  mfs_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rd_data_o (rd_data)
  );

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.found        = res_q.found;
  assign rsp_o.sel_id       = res_q.found ? rd_data : '0;
  assign rsp_o.sel_level    = res_q.sel_level;
  assign rsp_o.keep_running = res_q.keep_running;
  assign rsp_o.none_waiting = res_q.none_waiting;
  assign rsp_o.status       = res_q.status;

endmodule

// File: rtl/core/mfs_store.sv
// process id store shared by all levels, one write and one registered read port
module mfs_store (
  input  logic                       clk_i,
  input  mfs_pkg::mem_req_t          mem_req_i,
  output logic [mfs_pkg::ID_W-1:0]   rd_data_o
);
  import mfs_pkg::*;

  logic [ID_W-1:0] mem_q [NUM_LEVELS*QUEUE_DEPTH];
  logic [ID_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      mem_q[mem_req_i.wr_addr] <= mem_req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_req_i.rd_en) begin
      rd_data_q <= mem_q[mem_req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/mfs_ctrl.sv
// queue pointers, level counts, priority select and continue decision
module mfs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  mfs_pkg::req_t      req_i,
  output mfs_pkg::res_t      res_o,
  output mfs_pkg::mem_req_t  mem_req_o
);
  import mfs_pkg::*;

  logic [PTR_W-1:0]     head_q [NUM_LEVELS];
  logic [PTR_W-1:0]     head_d [NUM_LEVELS];
  logic [PTR_W-1:0]     tail_q [NUM_LEVELS];
  logic [PTR_W-1:0]     tail_d [NUM_LEVELS];
  logic [CNT_W-1:0]     cnt_q  [NUM_LEVELS];
  logic [CNT_W-1:0]     cnt_d  [NUM_LEVELS];
  logic [LVL_IDX_W-1:0] run_level_q, run_level_d;
  logic                 run_valid_q, run_valid_d;

  logic [LVL_IDX_W-1:0] push_lvl;
  logic                 clamp;
  logic                 full;
  logic                 any_ready;
  logic [LVL_IDX_W-1:0] sel_lvl;
  logic [SUM_W-1:0]     sum;

  // target level of an insert or requeue
  always_comb begin
    push_lvl = '0;
    clamp    = 1'b0;
    if (req_i.op == OP_REQUEUE && run_valid_q) begin
      if (run_level_q == LAST_IDX) begin
        push_lvl = LAST_IDX;
        clamp    = 1'b1;
      end else begin
        push_lvl = run_level_q + 1'b1;
      end
    end
  end

  assign full = (cnt_q[push_lvl] == CNT_FULL);
  assign sum  = SUM_W'(req_i.done_time) + SUM_W'(req_i.elapsed_time);

  // first nonempty level
  always_comb begin
    any_ready = 1'b0;
    sel_lvl   = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0) begin
        any_ready = 1'b1;
        sel_lvl   = LVL_IDX_W'(i);
      end
    end
  end

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    run_level_d = run_level_q;
    run_valid_d = run_valid_q;
    res_o       = '{found: 1'b0, sel_level: '0, keep_running: 1'b0,
                    none_waiting: 1'b0, status: ST_OK};
    mem_req_o   = '{wr_en: 1'b0, wr_addr: store_addr(push_lvl, tail_q[push_lvl]),
                    wr_data: req_i.proc_id, rd_en: 1'b0,
                    rd_addr: store_addr(sel_lvl, head_q[sel_lvl])};
    unique case (req_i.op) inside
      OP_INSERT, OP_REQUEUE: begin
        if (full) begin
          res_o.status = ST_FULL;
        end else begin
          mem_req_o.wr_en  = adv_i;
          tail_d[push_lvl] = next_ptr(tail_q[push_lvl]);
          cnt_d[push_lvl]  = cnt_q[push_lvl] + 1'b1;
          res_o.status     = clamp ? ST_CLAMP : ST_OK;
        end
      end
      OP_SELECT: begin
        if (any_ready) begin
          mem_req_o.rd_en = adv_i;
          head_d[sel_lvl] = next_ptr(head_q[sel_lvl]);
          cnt_d[sel_lvl]  = cnt_q[sel_lvl] - 1'b1;
          run_level_d     = sel_lvl;
          run_valid_d     = 1'b1;
          res_o.found     = 1'b1;
          res_o.sel_level = LEVEL_W'(sel_lvl);
        end
      end
      OP_CHECK: begin
        if (sum == SUM_W'(req_i.service_time)) begin
          res_o.keep_running = 1'b0;
        end else if (run_level_q == LAST_IDX) begin
          res_o.keep_running = 1'b1;
        end else begin
          res_o.keep_running = SUM_W'(req_i.elapsed_time) < (SUM_W'(1) << run_level_q);
        end
      end
      default: ;
    endcase
    res_o.none_waiting = 1'b1;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (cnt_d[i] != '0) begin
        res_o.none_waiting = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      run_level_q <= '0;
      run_valid_q <= 1'b0;
    end else if (adv_i) begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      run_level_q <= run_level_d;
      run_valid_q <= run_valid_d;
    end
  end

endmodule

// File: rtl/core/mfs_checker.sv
// port level checks of the scheduler and their bind
module mfs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic                         found_i,
  input logic [mfs_pkg::ID_W-1:0]     sel_id_i,
  input logic [mfs_pkg::LEVEL_W-1:0]  sel_level_i,
  input logic                         keep_running_i,
  input logic                         none_waiting_i,
  input mfs_pkg::status_e             status_i
);
  import mfs_pkg::*;

  // stalled response stays
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable({found_i, sel_id_i, sel_level_i, keep_running_i, none_waiting_i, status_i}))
    else $error("response changed while stalled");

  // no selection means zero id and level
  a_no_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !found_i |-> sel_id_i == '0 && sel_level_i == '0)
    else $error("id or level without a selection");

  // a response reports one kind of result only, levels stay in range
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(found_i && keep_running_i) &&
                    ((!found_i && !keep_running_i) || status_i == ST_OK) &&
                    (!found_i || sel_level_i <= LEVEL_W'(LAST_LEVEL)))
    else $error("mixed result kinds");

endmodule

bind multilevel_feedback_scheduler mfs_checker u_mfs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .found_i        (rsp_o.found),
  .sel_id_i       (rsp_o.sel_id),
  .sel_level_i    (rsp_o.sel_level),
  .keep_running_i (rsp_o.keep_running),
  .none_waiting_i (rsp_o.none_waiting),
  .status_i       (rsp_o.status)
);

// File: verif/mfs_sched_monitor.sv
// checker of the scheduler: predicts each response from accepted requests and compares it
module mfs_sched_monitor (
  input  logic clk_i,
  input  logic rst_ni,
  mfs_req_if   req_i,
  mfs_rsp_if   rsp_i,
  output int   mismatch_cnt_o,
  output int   pending_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mfs_pkg::*;

  typedef struct packed {
    logic               found;
    logic [ID_W-1:0]    sel_id;
    logic [LEVEL_W-1:0] sel_level;
    logic               keep_running;
    logic               none_waiting;
    status_e            status;
  } sched_rsp_t;

  logic [ID_W-1:0] id_store [NUM_LEVELS][QUEUE_DEPTH];
  int unsigned     head_idx [NUM_LEVELS];
  int unsigned     tail_idx [NUM_LEVELS];
  int unsigned     level_fill [NUM_LEVELS];
  int unsigned     run_level;
  bit              run_valid;
  sched_rsp_t      expected_rsp [$];
  sched_rsp_t      oldest_rsp;
  sched_rsp_t      newest_rsp;

  function automatic status_e enqueue_id(input int unsigned lvl, input logic [ID_W-1:0] id);
    if (level_fill[lvl] >= QUEUE_DEPTH) return ST_FULL;
    id_store[lvl][tail_idx[lvl]] = id;
    tail_idx[lvl] = (tail_idx[lvl] + 1) % QUEUE_DEPTH;
    level_fill[lvl]++;
    return ST_OK;
  endfunction

  function automatic sched_rsp_t predict_rsp(input op_e op, input logic [ID_W-1:0] id,
                                             input logic [TIME_W-1:0] done,
                                             input logic [TIME_W-1:0] elapsed,
                                             input logic [TIME_W-1:0] service);
    sched_rsp_t       r;
    int unsigned      target;
    bit               clamped;
    logic [SUM_W-1:0] sum;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        r.status = enqueue_id(0, id);
      end
      OP_REQUEUE: begin
        target  = run_valid ? run_level + 1 : 0;
        clamped = (target > LAST_LEVEL);
        if (clamped) target = LAST_LEVEL;
        r.status = enqueue_id(target, id);
        if (r.status == ST_OK && clamped) r.status = ST_CLAMP;
      end
      OP_SELECT: begin
        for (int lvl = 0; lvl < NUM_LEVELS; lvl++) begin
          if (!r.found && level_fill[lvl] != 0) begin
            r.found     = 1'b1;
            r.sel_id    = id_store[lvl][head_idx[lvl]];
            r.sel_level = LEVEL_W'(lvl);
            head_idx[lvl] = (head_idx[lvl] + 1) % QUEUE_DEPTH;
            level_fill[lvl]--;
            run_level = lvl;
            run_valid = 1'b1;
          end
        end
      end
      default: begin
        sum = SUM_W'(done) + SUM_W'(elapsed);
        if (sum == SUM_W'(service)) r.keep_running = 1'b0;
        else if (run_level >= LAST_LEVEL) r.keep_running = 1'b1;
        else r.keep_running = (32'(elapsed) < (32'd1 << run_level));
      end
    endcase
    r.none_waiting = 1'b1;
    for (int lvl = 0; lvl < NUM_LEVELS; lvl++)
      if (level_fill[lvl] != 0) r.none_waiting = 1'b0;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      mismatch_cnt_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int lvl = 0; lvl < NUM_LEVELS; lvl++) begin
        head_idx[lvl]   = 0;
        tail_idx[lvl]   = 0;
        level_fill[lvl] = 0;
      end
      run_level = 0;
      run_valid = 1'b0;
      expected_rsp.delete();
      mismatch_cnt_o = 0;
      pending_cnt_o  = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        newest_rsp = predict_rsp(req_i.op, req_i.proc_id, req_i.done_time,
                                 req_i.elapsed_time, req_i.service_time);
        expected_rsp = {expected_rsp, newest_rsp};
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t unexpected response: expected none actual id %0h level %0h",
                   $time, rsp_i.sel_id, rsp_i.sel_level);
          mismatch_cnt_o++;
        end else begin
          oldest_rsp = expected_rsp.pop_front();
          compare_field("found", 32'(oldest_rsp.found), 32'(rsp_i.found));
          compare_field("sel_id", 32'(oldest_rsp.sel_id), 32'(rsp_i.sel_id));
          compare_field("sel_level", 32'(oldest_rsp.sel_level), 32'(rsp_i.sel_level));
          compare_field("keep_running", 32'(oldest_rsp.keep_running),
                        32'(rsp_i.keep_running));
          compare_field("none_waiting", 32'(oldest_rsp.none_waiting),
                        32'(rsp_i.none_waiting));
          compare_field("status", 32'(oldest_rsp.status), 32'(rsp_i.status));
        end
      end
      pending_cnt_o = expected_rsp.size();
    end
  end

endmodule

// File: verif/multilevel_feedback_scheduler_tb.sv
// testbench top of the scheduler: clock, reset, request and response stimulus, verdict
module multilevel_feedback_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfs_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RAND_PER_PHASE = 290;
  localparam int SEGMENT_LEN    = 24;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } op_mix_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   tx_idle_pct = 22;
  int   rx_idle_pct = 66;
  bit   rx_hold = 1'b0;
  bit   rx_hold_done = 1'b0;
  int   cycles = 0;
  int   mismatch_cnt;
  int   pending_cnt;

  mfs_req_if req_if ();
  mfs_rsp_if rsp_if ();

  multilevel_feedback_scheduler u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  mfs_sched_monitor u_monitor (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .req_i          (req_if),
    .rsp_i          (rsp_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_req(input op_e op, input logic [ID_W-1:0] id,
                          input logic [TIME_W-1:0] done, input logic [TIME_W-1:0] elapsed,
                          input logic [TIME_W-1:0] service);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.op           <= op;
    req_if.proc_id      <= id;
    req_if.done_time    <= done;
    req_if.elapsed_time <= elapsed;
    req_if.service_time <= service;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic send_random(input op_mix_e mix);
    int  r;
    int  d;
    int  e;
    int  s;
    op_e op;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL:  op = (r < 45) ? OP_INSERT : (r < 80) ? OP_REQUEUE :
                      (r < 92) ? OP_SELECT : OP_CHECK;
      MIX_DRAIN: op = (r < 10) ? OP_INSERT : (r < 20) ? OP_REQUEUE :
                      (r < 80) ? OP_SELECT : OP_CHECK;
      default:   op = op_e'($urandom_range(3));
    endcase
    e = $urandom_range(1) ? $urandom_range(9) : $urandom_range(65535);
    d = $urandom_range(65535);
    s = $urandom_range(65535, 1);
    if ($urandom_range(99) < 30) begin
      d = $urandom_range(65535 - e);
      if (d + e == 0) d = 1;
      s = d + e;
    end
    send_req(op, ID_W'($urandom_range(255)), TIME_W'(d), TIME_W'(e), TIME_W'(s));
  endtask

  task automatic random_phase();
    op_mix_e mix;
    mix = MIX_EVEN;
    for (int n = 0; n < RAND_PER_PHASE; n++) begin
      if (n % SEGMENT_LEN == 0) mix = op_mix_e'($urandom_range(2));
      send_random(mix);
    end
  endtask

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold && !rx_hold_done) begin
        rx_hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[multilevel_feedback_scheduler] ERROR");
    $finish;
  end

  initial begin
    req_if.valid        = 1'b0;
    req_if.op           = OP_INSERT;
    req_if.proc_id      = '0;
    req_if.done_time    = '0;
    req_if.elapsed_time = '0;
    req_if.service_time = 16'd1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners: empty select, requeue before select, level walk, clamp, finish test
    send_req(OP_CHECK,   8'h00, 16'h0000, 16'h0000, 16'h0001);
    send_req(OP_SELECT,  8'h00, 16'h0000, 16'h0000, 16'h0001);
    send_req(OP_REQUEUE, 8'hFF, 16'h0000, 16'h0000, 16'h0001);
    send_req(OP_INSERT,  8'h00, 16'h0000, 16'h0000, 16'h0001);
    send_req(OP_SELECT,  8'h00, 16'h0000, 16'h0000, 16'h0001);
    send_req(OP_CHECK,   8'h00, 16'h0000, 16'h0001, 16'h0064);
    send_req(OP_REQUEUE, 8'hA5, 16'h0000, 16'h0000, 16'h0001);
    send_req(OP_SELECT,  8'h00, 16'h0000, 16'h0000, 16'h0001);
    send_req(OP_SELECT,  8'h00, 16'h0000, 16'h0000, 16'h0001);
    send_req(OP_CHECK,   8'h00, 16'h0000, 16'h0001, 16'h0064);
    send_req(OP_CHECK,   8'h00, 16'h0000, 16'h0002, 16'h0064);
    send_req(OP_REQUEUE, 8'h5A, 16'h0000, 16'h0000, 16'h0001);
    send_req(OP_SELECT,  8'h00, 16'h0000, 16'h0000, 16'h0001);
    send_req(OP_CHECK,   8'h00, 16'h0000, 16'h0003, 16'h0064);
    send_req(OP_REQUEUE, 8'h3C, 16'h0000, 16'h0000, 16'h0001);
    send_req(OP_SELECT,  8'h00, 16'h0000, 16'h0000, 16'h0001);
    send_req(OP_REQUEUE, 8'hC3, 16'h0000, 16'h0000, 16'h0001);
    send_req(OP_CHECK,   8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_req(OP_CHECK,   8'h00, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_req(OP_CHECK,   8'h00, 16'h0000, 16'h0001, 16'h0001);
    send_req(OP_SELECT,  8'h00, 16'h0000, 16'h0000, 16'h0001);
    send_req(OP_SELECT,  8'h00, 16'h0000, 16'h0000, 16'h0001);
    send_req(OP_REQUEUE, 8'h81, 16'h0000, 16'h0000, 16'h0001);

    rx_hold = 1'b1;
    random_phase();
    tx_idle_pct = 66;
    rx_idle_pct = 22;
    random_phase();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase();
    req_if.valid <= 1'b0;

    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("[multilevel_feedback_scheduler] OK");
    end else begin
      $display("[multilevel_feedback_scheduler] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/mfs_pkg.sv
rtl/core/mfs_if.sv
rtl/core/mfs_store.sv
rtl/core/mfs_ctrl.sv
rtl/core/multilevel_feedback_scheduler.sv
rtl/core/mfs_checker.sv
verif/mfs_sched_monitor.sv
verif/multilevel_feedback_scheduler_tb.sv
